[hdl/twp_pkg.sv]
// ----------------------------------------------------------------------------
// twp_pkg
// Shared types, codes and constant tag tables for the TLV whitelist parser.
// ----------------------------------------------------------------------------
package twp_pkg;

  // Default table sizes
  localparam int KEY_TABLE_ENTRIES = 8;
  localparam int APP_TABLE_ENTRIES = 16;
  localparam int TABLE_ROWS        = 16;

  // Byte-level constants
  localparam logic [7:0] PAD_ZERO  = 8'h00;
  localparam logic [7:0] PAD_ONES  = 8'hFF;
  localparam logic [4:0] TAG_MORE  = 5'h1F;
  localparam logic [8:0] NO_ADDR   = 9'h1FF;

  // Parser phase
  typedef enum logic [2:0] {
    PH_TAG1  = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENN  = 3'd3,
    PH_VALUE = 3'd4,
    PH_ERROR = 3'd5
  } twp_phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } twp_kind_t;

  // Message status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2
  } twp_status_t;

  // One table row: tag bytes, length bounds, store address
  typedef struct packed {
    logic [7:0] tag0;
    logic [7:0] tag1;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [8:0] addr;
  } twp_row_t;

  // Lookup request from the parser to the table
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
  } twp_lookup_t;

  // Lookup answer
  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } twp_match_t;

  // One result
  typedef struct packed {
    twp_kind_t   kind;
    logic [3:0]  entry;
    logic [8:0]  addr;
    logic [7:0]  data;
    twp_status_t status;
  } twp_result_t;

  // Key table; lo above hi marks a fixed length of hi
  localparam twp_row_t KEY_ROWS [TABLE_ROWS] = '{
    '{8'h9F, 8'h06, 8'd255, 8'd5,   9'd0},
    '{8'h9F, 8'h22, 8'd255, 8'd1,   9'd5},
    '{8'hDF, 8'h06, 8'd255, 8'd1,   9'd6},
    '{8'hDF, 8'h07, 8'd255, 8'd1,   9'd7},
    '{8'hDF, 8'h02, 8'd0,   8'd248, 9'd9},
    '{8'hDF, 8'h04, 8'd1,   8'd3,   9'd258},
    '{8'hDF, 8'h03, 8'd0,   8'd20,  9'd262},
    '{8'hDF, 8'h05, 8'd255, 8'd8,   9'd282},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0},
    '{8'h00, 8'h00, 8'd0,   8'd0,   9'd0}
  };

  // Application table
  localparam twp_row_t APP_ROWS [TABLE_ROWS] = '{
    '{8'h9F, 8'h06, 8'd5,   8'd16,  9'd1},
    '{8'hDF, 8'h01, 8'd255, 8'd1,   9'd17},
    '{8'h9F, 8'h09, 8'd255, 8'd2,   9'd18},
    '{8'hDF, 8'h11, 8'd255, 8'd5,   9'd20},
    '{8'hDF, 8'h12, 8'd255, 8'd5,   9'd25},
    '{8'hDF, 8'h13, 8'd255, 8'd5,   9'd30},
    '{8'h9F, 8'h1B, 8'd255, 8'd4,   9'd35},
    '{8'hDF, 8'h15, 8'd255, 8'd4,   9'd39},
    '{8'hDF, 8'h16, 8'd255, 8'd1,   9'd43},
    '{8'hDF, 8'h17, 8'd255, 8'd1,   9'd44},
    '{8'hDF, 8'h14, 8'd0,   8'd128, 9'd46},
    '{8'hDF, 8'h18, 8'd255, 8'd1,   9'd174},
    '{8'h9F, 8'h7B, 8'd255, 8'd6,   9'd175},
    '{8'hDF, 8'h21, 8'd255, 8'd6,   9'd181},
    '{8'hDF, 8'h20, 8'd255, 8'd6,   9'd187},
    '{8'hDF, 8'h19, 8'd255, 8'd6,   9'd193}
  };

endpackage

[hdl/twp_if.sv]
// ----------------------------------------------------------------------------
// twp channel interfaces
// Valid/ready channels for the parser: byte input, result output, config.
// ----------------------------------------------------------------------------
interface twp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface twp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] entry_index;
  logic [8:0] store_address;
  logic [7:0] data_value;
  logic [1:0] status;

  modport source (output valid, output kind, output entry_index, output store_address,
                  output data_value, output status, input ready);
  modport sink   (input valid, input kind, input entry_index, input store_address,
                  input data_value, input status, output ready);
endinterface

interface twp_cfg_if;
  logic valid;
  logic ready;
  logic table_select;

  modport source (output valid, output table_select, input ready);
  modport sink   (input valid, input table_select, output ready);
endinterface

[hdl/twp_tag_table.sv]
// ----------------------------------------------------------------------------
// twp_tag_table
// Parallel tag compare against the selected constant table, first match
// wins; also reads the row of the currently matched entry.
// ----------------------------------------------------------------------------
module twp_tag_table #(
  parameter int KeyEntries = twp_pkg::KEY_TABLE_ENTRIES,
  parameter int AppEntries = twp_pkg::APP_TABLE_ENTRIES
) (
  input  logic               table_select,
  input  twp_pkg::twp_lookup_t lk_req,
  output twp_pkg::twp_match_t  lk_match,
  input  logic [3:0]         rd_idx,
  output twp_pkg::twp_row_t    rd_row
);

  logic [twp_pkg::TABLE_ROWS-1:0] key_hit;
  logic [twp_pkg::TABLE_ROWS-1:0] app_hit;
  logic [twp_pkg::TABLE_ROWS-1:0] sel_hit;

  // Compare every row of both tables
  always_comb begin
    for (int i = 0; i < twp_pkg::TABLE_ROWS; i++) begin
      key_hit[i] = (i < KeyEntries) &&
                   (twp_pkg::KEY_ROWS[i].tag0 == lk_req.first) &&
                   (!lk_req.two || (twp_pkg::KEY_ROWS[i].tag1 == lk_req.second));
      app_hit[i] = (i < AppEntries) &&
                   (twp_pkg::APP_ROWS[i].tag0 == lk_req.first) &&
                   (!lk_req.two || (twp_pkg::APP_ROWS[i].tag1 == lk_req.second));
    end
  end

  assign sel_hit = table_select ? app_hit : key_hit;

  // Pick the lowest matching row
  always_comb begin
    lk_match.hit = |sel_hit;
    lk_match.idx = 4'd0;
    for (int i = twp_pkg::TABLE_ROWS - 1; i >= 0; i--) begin
      if (sel_hit[i]) begin
        lk_match.idx = 4'(i);
      end
    end
  end

  // Row of the matched entry for the length check
  assign rd_row = table_select ? twp_pkg::APP_ROWS[rd_idx] : twp_pkg::KEY_ROWS[rd_idx];

endmodule

[hdl/twp_parse_core.sv]
// ----------------------------------------------------------------------------
// twp_parse_core
// Message state machine: tag, length and value phases, length check,
// duplicate tracking and result formation for one byte per cycle while proc is high.
// ----------------------------------------------------------------------------
module twp_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output twp_pkg::twp_lookup_t lk_req,
  input  twp_pkg::twp_match_t  lk_match,
  output logic [3:0]           rd_idx,
  input  twp_pkg::twp_row_t    rd_row,
  output logic                 produce,
  output twp_pkg::twp_result_t res
);

  twp_pkg::twp_phase_t  phase_r, phase_nxt;
  logic [7:0]           tag_first_r, tag_first_nxt;
  logic [3:0]           entry_r, entry_nxt;
  logic                 matched_r, matched_nxt;
  logic [6:0]           len_left_r, len_left_nxt;
  logic [15:0]          len_acc_r, len_acc_nxt;
  logic [15:0]          val_left_r, val_left_nxt;
  logic [8:0]           wr_addr_r, wr_addr_nxt;
  logic [15:0]          seen_r, seen_nxt;
  twp_pkg::twp_status_t err_r, err_nxt;

  logic        is_pad;
  logic        two_byte;
  logic [6:0]  len_left_dec;
  logic [15:0] val_left_dec;
  logic [15:0] ld_len;
  logic        ld_fire;
  logic        row_var;
  logic        row_bad;
  logic        dup;
  logic        ld_err;

  logic                emit_v;
  twp_pkg::twp_kind_t  emit_kind;
  logic [8:0]          emit_addr;
  logic [7:0]          emit_data;

  // Lookup request and row read
  assign lk_req.first  = (phase_r == twp_pkg::PH_TAG2) ? tag_first_r : data_byte;
  assign lk_req.second = data_byte;
  assign lk_req.two    = (phase_r == twp_pkg::PH_TAG2);
  assign rd_idx        = entry_r;

  assign is_pad       = (data_byte == twp_pkg::PAD_ZERO) || (data_byte == twp_pkg::PAD_ONES);
  assign two_byte     = (data_byte[4:0] == twp_pkg::TAG_MORE);
  assign len_left_dec = len_left_r - 7'd1;
  assign val_left_dec = val_left_r - 16'd1;

  // Evaluate the element length when its last length byte arrives
  always_comb begin
    ld_len  = 16'd0;
    ld_fire = 1'b0;
    case (phase_r)
      twp_pkg::PH_LEN1: begin
        ld_len  = data_byte[7] ? 16'd0 : {8'd0, data_byte};
        ld_fire = !data_byte[7] || (data_byte[6:0] == 7'd0);
      end
      twp_pkg::PH_LENN: begin
        ld_len  = {len_acc_r[7:0], data_byte};
        ld_fire = (len_left_dec == 7'd0);
      end
      default: begin
        ld_len  = 16'd0;
        ld_fire = 1'b0;
      end
    endcase
  end

  assign row_var = (rd_row.lo <= rd_row.hi);
  assign row_bad = row_var ? ((ld_len < {8'd0, rd_row.lo}) || (ld_len > {8'd0, rd_row.hi}))
                           : (ld_len != {8'd0, rd_row.hi});
  assign dup     = seen_r[entry_r];
  assign ld_err  = ld_fire && matched_r && (dup || row_bad);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      twp_pkg::PH_TAG1: begin
        if (!is_pad) begin
          phase_nxt = two_byte ? twp_pkg::PH_TAG2 : twp_pkg::PH_LEN1;
        end
      end
      twp_pkg::PH_TAG2: begin
        phase_nxt = twp_pkg::PH_LEN1;
      end
      twp_pkg::PH_LEN1, twp_pkg::PH_LENN: begin
        if (ld_fire) begin
          if (ld_err) begin
            phase_nxt = twp_pkg::PH_ERROR;
          end else begin
            phase_nxt = (ld_len != 16'd0) ? twp_pkg::PH_VALUE : twp_pkg::PH_TAG1;
          end
        end else begin
          phase_nxt = twp_pkg::PH_LENN;
        end
      end
      twp_pkg::PH_VALUE: begin
        if (val_left_dec == 16'd0) begin
          phase_nxt = twp_pkg::PH_TAG1;
        end
      end
      twp_pkg::PH_ERROR: begin
        phase_nxt = twp_pkg::PH_ERROR;
      end
      default: begin
        phase_nxt = twp_pkg::PH_TAG1;
      end
    endcase
    if (last_byte) begin
      phase_nxt = twp_pkg::PH_TAG1;
    end
  end

  // Message state update
  always_comb begin
    tag_first_nxt = tag_first_r;
    entry_nxt     = entry_r;
    matched_nxt   = matched_r;
    len_left_nxt  = len_left_r;
    len_acc_nxt   = len_acc_r;
    val_left_nxt  = val_left_r;
    wr_addr_nxt   = wr_addr_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    case (phase_r)
      twp_pkg::PH_TAG1: begin
        if (!is_pad) begin
          tag_first_nxt = data_byte;
          if (!two_byte) begin
            matched_nxt = lk_match.hit;
            entry_nxt   = lk_match.hit ? lk_match.idx : 4'd0;
          end
        end
      end
      twp_pkg::PH_TAG2: begin
        matched_nxt = lk_match.hit;
        entry_nxt   = lk_match.hit ? lk_match.idx : 4'd0;
      end
      twp_pkg::PH_LEN1: begin
        if (data_byte[7]) begin
          len_acc_nxt  = 16'd0;
          len_left_nxt = data_byte[6:0];
        end else begin
          len_acc_nxt = {8'd0, data_byte};
        end
      end
      twp_pkg::PH_LENN: begin
        len_acc_nxt  = ld_len;
        len_left_nxt = len_left_dec;
      end
      twp_pkg::PH_VALUE: begin
        if (matched_r) begin
          wr_addr_nxt = wr_addr_r + 9'd1;
        end
        val_left_nxt = val_left_dec;
      end
      default: begin
        tag_first_nxt = tag_first_r;
      end
    endcase

    // Close the length: check the row, mark it seen, load the value count
    if (ld_fire) begin
      if (matched_r) begin
        if (dup) begin
          err_nxt = twp_pkg::ST_DUP;
        end else if (row_bad) begin
          err_nxt = twp_pkg::ST_RANGE;
        end else begin
          seen_nxt    = seen_r | (16'd1 << entry_r);
          wr_addr_nxt = rd_row.addr;
        end
      end
      if (!ld_err) begin
        val_left_nxt = ld_len;
      end
    end

    // Drop all message state after the last byte
    if (last_byte) begin
      tag_first_nxt = 8'd0;
      entry_nxt     = 4'd0;
      matched_nxt   = 1'b0;
      len_left_nxt  = 7'd0;
      len_acc_nxt   = 16'd0;
      val_left_nxt  = 16'd0;
      wr_addr_nxt   = 9'd0;
      seen_nxt      = 16'd0;
    end
  end

  // Result of this byte
  always_comb begin
    emit_v    = 1'b0;
    emit_kind = twp_pkg::KIND_VALUE;
    emit_addr = twp_pkg::NO_ADDR;
    emit_data = 8'd0;
    if (ld_fire && matched_r) begin
      if (ld_err) begin
        emit_v    = 1'b1;
        emit_kind = twp_pkg::KIND_ERROR;
      end else if (row_var) begin
        emit_v    = 1'b1;
        emit_kind = twp_pkg::KIND_LENGTH;
        emit_addr = rd_row.addr - 9'd1;
        emit_data = ld_len[7:0];
      end
    end else if ((phase_r == twp_pkg::PH_VALUE) && matched_r) begin
      emit_v    = 1'b1;
      emit_kind = twp_pkg::KIND_VALUE;
      emit_addr = wr_addr_r;
      emit_data = data_byte;
    end

    res.entry  = entry_r;
    res.addr   = emit_addr;
    res.data   = emit_data;
    res.kind   = emit_kind;
    res.status = (emit_kind == twp_pkg::KIND_ERROR) ? err_nxt : twp_pkg::ST_OK;
    produce    = emit_v;

    // End of message: carry a value or length result, else the empty form
    if (last_byte) begin
      produce    = 1'b1;
      res.kind   = twp_pkg::KIND_END;
      res.status = err_nxt;
      if (!(emit_v && (emit_kind != twp_pkg::KIND_ERROR))) begin
        res.entry = 4'd0;
        res.addr  = twp_pkg::NO_ADDR;
        res.data  = 8'd0;
      end
    end
  end

  // Advance state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= twp_pkg::PH_TAG1;
      tag_first_r <= 8'd0;
      entry_r     <= 4'd0;
      matched_r   <= 1'b0;
      len_left_r  <= 7'd0;
      len_acc_r   <= 16'd0;
      val_left_r  <= 16'd0;
      wr_addr_r   <= 9'd0;
      seen_r      <= 16'd0;
      err_r       <= twp_pkg::ST_OK;
    end else if (proc) begin
      phase_r     <= phase_nxt;
      tag_first_r <= tag_first_nxt;
      entry_r     <= entry_nxt;
      matched_r   <= matched_nxt;
      len_left_r  <= len_left_nxt;
      len_acc_r   <= len_acc_nxt;
      val_left_r  <= val_left_nxt;
      wr_addr_r   <= wr_addr_nxt;
      seen_r      <= seen_nxt;
      err_r       <= last_byte ? twp_pkg::ST_OK : err_nxt;
    end
  end

  // Error phase always carries a nonzero code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == twp_pkg::PH_ERROR |-> err_r != twp_pkg::ST_OK)
    else $error("error phase without error code");

  // Last byte returns the message state to its start
  a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    proc && last_byte |=> phase_r == twp_pkg::PH_TAG1 && seen_r == 16'd0
                          && err_r == twp_pkg::ST_OK)
    else $error("message state not cleared after last byte");

  // Error results carry a status and no address
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    produce && res.kind == twp_pkg::KIND_ERROR |->
      res.status != twp_pkg::ST_OK && res.addr == twp_pkg::NO_ADDR)
    else $error("malformed error result");

endmodule

[hdl/tlv_whitelist_parser.sv]
// ----------------------------------------------------------------------------
// tlv_whitelist_parser
// Streaming BER-TLV parser checking tags against a constant whitelist table.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | data_byte[8], last_byte[1]
//   out_ch  | out | valid/ready        | kind[2], entry_index[4],
//           |     |                    | store_address[9], data_value[8], status[2]
//   cfg_ch  | in  | valid/ready (=1)   | table_select[1]
//
// One byte per cycle sustained while the result register is not stalled; a byte
// is held in the input register, then processed into the result register.
// Reset clears all control state; no clearing pass is needed.
// A stalled result register holds the input register, which then drops ready;
// bytes that give no result still wait for a free result slot.
// ----------------------------------------------------------------------------
module tlv_whitelist_parser #(
  parameter int KEY_TABLE_ENTRIES = twp_pkg::KEY_TABLE_ENTRIES,
  parameter int APP_TABLE_ENTRIES = twp_pkg::APP_TABLE_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  twp_in_if.sink    in_ch,
  twp_out_if.source out_ch,
  twp_cfg_if.sink   cfg_ch
);

  logic       sel_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       adv;

  logic                 out_valid_r;
  twp_pkg::twp_result_t out_res_r;

  twp_pkg::twp_lookup_t lk_req;
  twp_pkg::twp_match_t  lk_match;
  logic [3:0]           rd_idx;
  twp_pkg::twp_row_t    rd_row;
  logic                 produce;
  twp_pkg::twp_result_t res;

  // Config register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      sel_r <= cfg_ch.table_select;
    end
  end

  // Input register: advance when the result slot is free or being taken
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  twp_tag_table #(
    .KeyEntries (KEY_TABLE_ENTRIES),
    .AppEntries (APP_TABLE_ENTRIES)
  ) u_table (
    .table_select (sel_r),
    .lk_req       (lk_req),
    .lk_match     (lk_match),
    .rd_idx       (rd_idx),
    .rd_row       (rd_row)
  );

  twp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .lk_req    (lk_req),
    .lk_match  (lk_match),
    .rd_idx    (rd_idx),
    .rd_row    (rd_row),
    .produce   (produce),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= produce;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_res_r.kind;
  assign out_ch.entry_index   = out_res_r.entry;
  assign out_ch.store_address = out_res_r.addr;
  assign out_ch.data_value    = out_res_r.data;
  assign out_ch.status        = out_res_r.status;

  // Ready drops only behind a stalled result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

  // A produced result lands in the result register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && produce |=> out_valid_r)
    else $error("produced result lost");

  // A held byte is never dropped while it waits
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("waiting byte dropped");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV whitelist parser bench
// Streams BER-TLV messages one byte per request into the parser and checks
// every result record against a cycle-free parser model kept in the bench.
// A short table of hand-picked bytes goes first, with pinned records where
// they are obvious; random messages follow, in both tag tables and under four
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int KEY_COUNT    = 8;
  localparam int APP_COUNT    = 16;
  localparam int RANDOM_BYTES = 1900;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PROBE_COUNT  = 25;

  localparam int SEND_IDLE [4] = '{0, 50, 0, 37};
  localparam int RX_STALL  [4] = '{0, 0, 50, 37};

  // One whitelist rule: tag bytes, length bounds (lo above hi: fixed hi), address
  typedef struct packed {
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [8:0] addr;
  } tag_rule_t;

  localparam tag_rule_t KEY_RULES [8] = '{
    '{8'h9F, 8'h06, 8'd255, 8'd5,   9'd0},
    '{8'h9F, 8'h22, 8'd255, 8'd1,   9'd5},
    '{8'hDF, 8'h06, 8'd255, 8'd1,   9'd6},
    '{8'hDF, 8'h07, 8'd255, 8'd1,   9'd7},
    '{8'hDF, 8'h02, 8'd0,   8'd248, 9'd9},
    '{8'hDF, 8'h04, 8'd1,   8'd3,   9'd258},
    '{8'hDF, 8'h03, 8'd0,   8'd20,  9'd262},
    '{8'hDF, 8'h05, 8'd255, 8'd8,   9'd282}
  };

  localparam tag_rule_t APP_RULES [16] = '{
    '{8'h9F, 8'h06, 8'd5,   8'd16,  9'd1},
    '{8'hDF, 8'h01, 8'd255, 8'd1,   9'd17},
    '{8'h9F, 8'h09, 8'd255, 8'd2,   9'd18},
    '{8'hDF, 8'h11, 8'd255, 8'd5,   9'd20},
    '{8'hDF, 8'h12, 8'd255, 8'd5,   9'd25},
    '{8'hDF, 8'h13, 8'd255, 8'd5,   9'd30},
    '{8'h9F, 8'h1B, 8'd255, 8'd4,   9'd35},
    '{8'hDF, 8'h15, 8'd255, 8'd4,   9'd39},
    '{8'hDF, 8'h16, 8'd255, 8'd1,   9'd43},
    '{8'hDF, 8'h17, 8'd255, 8'd1,   9'd44},
    '{8'hDF, 8'h14, 8'd0,   8'd128, 9'd46},
    '{8'hDF, 8'h18, 8'd255, 8'd1,   9'd174},
    '{8'h9F, 8'h7B, 8'd255, 8'd6,   9'd175},
    '{8'hDF, 8'h21, 8'd255, 8'd6,   9'd181},
    '{8'hDF, 8'h20, 8'd255, 8'd6,   9'd187},
    '{8'hDF, 8'h19, 8'd255, 8'd6,   9'd193}
  };

  // Directed byte with an optional pinned record
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 pinned;
    twp_pkg::twp_result_t want;
  } probe_t;

  localparam probe_t PROBES [PROBE_COUNT] = '{
    // padding at tag position, then a ranged key entry in long form
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hDF, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b1,
      '{twp_pkg::KIND_LENGTH, 4'd4, 9'd8,   8'h02, twp_pkg::ST_OK}},
    '{8'h00, 1'b0, 1'b1,
      '{twp_pkg::KIND_VALUE,  4'd4, 9'd9,   8'h00, twp_pkg::ST_OK}},
    '{8'hFF, 1'b0, 1'b1,
      '{twp_pkg::KIND_VALUE,  4'd4, 9'd10,  8'hFF, twp_pkg::ST_OK}},
    // same tag again: duplicate, then bytes dropped until the last one
    '{8'hDF, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{twp_pkg::KIND_ERROR,  4'd4, twp_pkg::NO_ADDR, 8'h00, twp_pkg::ST_DUP}},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b1, 1'b1,
      '{twp_pkg::KIND_END,    4'd0, twp_pkg::NO_ADDR, 8'h00, twp_pkg::ST_DUP}},
    // long form with no length bytes gives zero, below the entry's minimum
    '{8'hDF, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1,
      '{twp_pkg::KIND_ERROR,  4'd5, twp_pkg::NO_ADDR, 8'h00, twp_pkg::ST_RANGE}},
    '{8'h00, 1'b1, 1'b1,
      '{twp_pkg::KIND_END,    4'd0, twp_pkg::NO_ADDR, 8'h00, twp_pkg::ST_RANGE}},
    // unknown two-byte tag skipped, then a fixed entry cut short
    '{8'h1F, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'hDF, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b1, 1'b1,
      '{twp_pkg::KIND_END,    4'd7, 9'd282, 8'h7E, twp_pkg::ST_OK}}
  };

  logic clk;
  logic rst_n;

  twp_in_if  in_ch ();
  twp_out_if out_ch ();
  twp_cfg_if cfg_ch ();

  tlv_whitelist_parser #(
    .KEY_TABLE_ENTRIES(KEY_COUNT),
    .APP_TABLE_ENTRIES(APP_COUNT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Parser model state
  logic                 table_sel;
  twp_pkg::twp_phase_t  msg_phase;
  logic [7:0]           tag_lead;
  logic [3:0]           row_idx;
  logic                 row_hit;
  logic [6:0]           len_bytes_left;
  logic [15:0]          len_sum;
  logic [15:0]          value_left;
  logic [8:0]           store_ptr;
  logic [15:0]          seen_rows;
  twp_pkg::twp_status_t msg_status;
  bit                   step_has;
  twp_pkg::twp_result_t step_rec;

  twp_pkg::twp_result_t records_due [$];
  twp_pkg::twp_result_t head_rec;
  logic [7:0]           msg_bytes [$];

  int sender_idle_pct;
  int rx_stall_pct;
  int fail_count;
  int cycle_count;
  int total_bytes;
  int msg_count;
  int kind_tally [4];

  always #5 clk = ~clk;

  // Bail out if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d records still due", cycle_count,
             records_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stall at random
  always @(posedge clk)
    out_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99, 0) >= rx_stall_pct);

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest record due
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (records_due.size() == 0) begin
        $error("result with nothing due: kind %0d entry %0d addr %0d", out_ch.kind,
               out_ch.entry_index, out_ch.store_address);
        fail_count++;
      end else begin
        head_rec = records_due.pop_front();
        check_field("kind", head_rec.kind, out_ch.kind);
        check_field("entry_index", head_rec.entry, out_ch.entry_index);
        check_field("store_address", head_rec.addr, out_ch.store_address);
        check_field("data_value", head_rec.data, out_ch.data_value);
        check_field("status", head_rec.status, out_ch.status);
        kind_tally[head_rec.kind]++;
      end
    end
  end

  function automatic tag_rule_t rule_at(input logic app, input logic [3:0] idx);
    if (app) return APP_RULES[idx];
    if (idx < KEY_COUNT) return KEY_RULES[idx[2:0]];
    return '0;
  endfunction

  task automatic clear_message();
    msg_phase      = twp_pkg::PH_TAG1;
    tag_lead       = '0;
    row_idx        = '0;
    row_hit        = 1'b0;
    len_bytes_left = '0;
    len_sum        = '0;
    value_left     = '0;
    store_ptr      = '0;
    seen_rows      = '0;
    msg_status     = twp_pkg::ST_OK;
  endtask

  task automatic post_record(input twp_pkg::twp_kind_t kind, input logic [8:0] addr,
                             input logic [7:0] data);
    step_has        = 1'b1;
    step_rec.kind   = kind;
    step_rec.entry  = row_idx;
    step_rec.addr   = addr;
    step_rec.data   = data;
    step_rec.status = (kind == twp_pkg::KIND_ERROR) ? msg_status : twp_pkg::ST_OK;
  endtask

  // First rule of the selected table that matches the tag wins
  task automatic find_rule(input logic [7:0] first, input logic [7:0] second,
                           input logic two);
    tag_rule_t rule;
    int count;
    count   = table_sel ? APP_COUNT : KEY_COUNT;
    row_hit = 1'b0;
    row_idx = '0;
    for (int i = 0; i < count && !row_hit; i++) begin
      rule = rule_at(table_sel, i[3:0]);
      if (rule.t0 == first && (!two || rule.t1 == second)) begin
        row_hit = 1'b1;
        row_idx = i[3:0];
      end
    end
  endtask

  // Length complete: duplicate check, then range check, then open the value
  task automatic close_length();
    tag_rule_t rule;
    logic ranged;
    logic bad;
    if (row_hit) begin
      rule   = rule_at(table_sel, row_idx);
      ranged = rule.lo <= rule.hi;
      bad    = ranged ? (len_sum < rule.lo || len_sum > rule.hi) : (len_sum != rule.hi);
      if (seen_rows[row_idx] || bad) begin
        msg_status = seen_rows[row_idx] ? twp_pkg::ST_DUP : twp_pkg::ST_RANGE;
        msg_phase  = twp_pkg::PH_ERROR;
        post_record(twp_pkg::KIND_ERROR, twp_pkg::NO_ADDR, 8'h00);
        return;
      end
      seen_rows[row_idx] = 1'b1;
      store_ptr = rule.addr;
      if (ranged) post_record(twp_pkg::KIND_LENGTH, rule.addr - 9'd1, len_sum[7:0]);
    end
    value_left = len_sum;
    msg_phase  = (len_sum != 0) ? twp_pkg::PH_VALUE : twp_pkg::PH_TAG1;
  endtask

  // Advance the model by one byte; return the record it yields, if any
  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output bit has_rec, output twp_pkg::twp_result_t rec);
    logic carry;
    step_has = 1'b0;
    step_rec = '0;
    case (msg_phase)
      twp_pkg::PH_TAG1: begin
        if (b != twp_pkg::PAD_ZERO && b != twp_pkg::PAD_ONES) begin
          tag_lead = b;
          if (b[4:0] == twp_pkg::TAG_MORE) begin
            msg_phase = twp_pkg::PH_TAG2;
          end else begin
            find_rule(b, 8'h00, 1'b0);
            msg_phase = twp_pkg::PH_LEN1;
          end
        end
      end
      twp_pkg::PH_TAG2: begin
        find_rule(tag_lead, b, 1'b1);
        msg_phase = twp_pkg::PH_LEN1;
      end
      twp_pkg::PH_LEN1: begin
        if (!b[7]) begin
          len_sum = {8'h00, b};
          close_length();
        end else begin
          len_sum        = '0;
          len_bytes_left = b[6:0];
          if (len_bytes_left == 0) close_length();
          else msg_phase = twp_pkg::PH_LENN;
        end
      end
      twp_pkg::PH_LENN: begin
        len_sum        = {len_sum[7:0], b};
        len_bytes_left = len_bytes_left - 7'd1;
        if (len_bytes_left == 0) close_length();
      end
      twp_pkg::PH_VALUE: begin
        if (row_hit) begin
          post_record(twp_pkg::KIND_VALUE, store_ptr, b);
          store_ptr = store_ptr + 9'd1;
        end
        value_left = value_left - 16'd1;
        if (value_left == 0) msg_phase = twp_pkg::PH_TAG1;
      end
      default: ;
    endcase

    has_rec = step_has;
    rec     = step_rec;
    if (lst) begin
      carry      = step_has && (step_rec.kind == twp_pkg::KIND_VALUE ||
                                step_rec.kind == twp_pkg::KIND_LENGTH);
      has_rec    = 1'b1;
      rec.kind   = twp_pkg::KIND_END;
      rec.entry  = carry ? step_rec.entry : 4'd0;
      rec.addr   = carry ? step_rec.addr : twp_pkg::NO_ADDR;
      rec.data   = carry ? step_rec.data : 8'h00;
      rec.status = msg_status;
      clear_message();
    end
  endtask

  // Offer one byte after a random gap, then log the record it owes
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic pinned,
                           input twp_pkg::twp_result_t pinned_rec);
    bit has_rec;
    twp_pkg::twp_result_t rec;
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk); while (!in_ch.ready);
    total_bytes++;
    if (lst) msg_count++;
    parse_byte(b, lst, has_rec, rec);
    if (pinned) begin
      has_rec = 1'b1;
      rec     = pinned_rec;
    end
    if (has_rec) records_due.push_back(rec);
  endtask

  // Hold off until every record due has come and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_select(input logic sel);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.table_select <= sel;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    table_sel = sel;
  endtask

  // Build one message: mostly whitelisted elements with random content
  task automatic build_message();
    tag_rule_t rule;
    logic use_app;
    logic bad;
    int elements, pick, len, span, form, n, cut;
    logic [7:0] lead;
    msg_bytes.delete();
    elements = $urandom_range(1, 5);
    for (int e = 0; e < elements; e++) begin
      if ($urandom_range(0, 7) == 0)
        msg_bytes.push_back($urandom_range(0, 1) ? twp_pkg::PAD_ONES : twp_pkg::PAD_ZERO);
      pick = $urandom_range(0, 99);
      bad  = 1'b0;
      if (pick < 80) begin
        // table entry, now and then from the other table
        use_app = table_sel ^ (pick >= 70);
        rule = rule_at(use_app, 4'($urandom_range(0, (use_app ? APP_COUNT : KEY_COUNT) - 1)));
        msg_bytes.push_back(rule.t0);
        msg_bytes.push_back(rule.t1);
        bad = ($urandom_range(0, 9) == 0);
        if (rule.lo > rule.hi) begin
          len = bad ? ($urandom_range(0, 1) ? int'(rule.hi) + 1 : int'(rule.hi) - 1)
                    : int'(rule.hi);
        end else if (bad) begin
          len = (rule.lo > 0 && $urandom_range(0, 1)) ? int'(rule.lo) - 1 : int'(rule.hi) + 1;
        end else begin
          span = int'(rule.hi) - int'(rule.lo);
          if (span > 6) span = 6;
          len = ($urandom_range(0, 7) == 0) ? int'(rule.hi)
                                            : int'(rule.lo) + $urandom_range(0, span);
        end
      end else if (pick < 92) begin
        // unknown tag, one or two bytes
        lead = 8'($urandom_range(1, 254));
        msg_bytes.push_back(lead);
        if (lead[4:0] == twp_pkg::TAG_MORE) msg_bytes.push_back(8'($urandom_range(0, 255)));
        len = $urandom_range(0, 6);
      end else begin
        // raw noise
        n = $urandom_range(1, 3);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
        continue;
      end

      // length in short form or one of several long forms
      form = $urandom_range(0, 3);
      if (form == 0 && len <= 127) begin
        msg_bytes.push_back(8'(len));
      end else if (form <= 1) begin
        if (len == 0) begin
          msg_bytes.push_back(8'h80);
        end else begin
          msg_bytes.push_back(8'h81);
          msg_bytes.push_back(8'(len));
        end
      end else if (form == 2) begin
        msg_bytes.push_back(8'h82);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'(len));
      end else begin
        // top byte drops out of the 16-bit accumulator
        msg_bytes.push_back(8'h83);
        msg_bytes.push_back(8'($urandom_range(0, 255)));
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'(len));
      end

      n = (bad && len > 2) ? 2 : len;
      repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
      if (bad) break;
    end

    // now and then cut the message short
    if ($urandom_range(0, 9) == 0 && msg_bytes.size() > 1) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endtask

  initial begin
    int target;
    int mode;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.last_byte     = 1'b0;
    out_ch.ready        = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.table_select = 1'b0;
    sender_idle_pct     = 0;
    rx_stall_pct        = 0;
    fail_count          = 0;
    cycle_count         = 0;
    total_bytes         = 0;
    msg_count           = 0;
    kind_tally          = '{0, 0, 0, 0};
    table_sel           = 1'b0;
    clear_message();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bytes on the key table, no idling
    write_table_select(1'b0);
    for (int i = 0; i < PROBE_COUNT; i++)
      send_byte(PROBES[i].data, PROBES[i].last, PROBES[i].pinned, PROBES[i].want);

    // Random messages: alternate tables, step through the idling mixes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      mode            = p / 2;
      sender_idle_pct = SEND_IDLE[mode];
      rx_stall_pct    = RX_STALL[mode];
      write_table_select(p[0]);
      target = total_bytes + RANDOM_BYTES / PHASES;
      while (total_bytes < target) begin
        build_message();
        for (int k = 0; k < msg_bytes.size(); k++)
          send_byte(msg_bytes[k], k == msg_bytes.size() - 1, 1'b0, '0);
      end
    end
    settle();

    if (records_due.size() != 0) begin
      $error("%0d records never arrived", records_due.size());
      fail_count++;
    end
    $display("Streamed %0d bytes in %0d messages through both tag tables and four idle mixes.",
             total_bytes, msg_count);
    $display("Checked results: %0d value, %0d length, %0d end, %0d error; %0d mismatches.",
             kind_tally[twp_pkg::KIND_VALUE], kind_tally[twp_pkg::KIND_LENGTH],
             kind_tally[twp_pkg::KIND_END], kind_tally[twp_pkg::KIND_ERROR], fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/twp_pkg.sv
hdl/twp_if.sv
hdl/twp_tag_table.sv
hdl/twp_parse_core.sv
hdl/tlv_whitelist_parser.sv
bench/testbench.sv
